/* rtl/core/kls_pkg.sv */
// ----------------------------------------------------------------------------
// kls_pkg
// Shared types, token kind codes and keyword table for the keyword lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package kls_pkg;

  localparam int KW_COUNT = 46;

  // token kinds
  localparam logic [6:0] KIND_END    = 7'd0;
  localparam logic [6:0] KIND_IDENT  = 7'd1;
  localparam logic [6:0] KIND_NUMBER = 7'd2;
  localparam logic [6:0] KIND_STRING = 7'd3;
  localparam logic [6:0] KIND_KW0    = 7'd4;
  localparam logic [6:0] KIND_EQEQ   = 7'd50;
  localparam logic [6:0] KIND_ASSIGN = 7'd51;
  localparam logic [6:0] KIND_NOTEQ  = 7'd52;
  localparam logic [6:0] KIND_PUNCT0 = 7'd53;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_BANG    = 2'd2;
  localparam logic [1:0] ERR_CHAR    = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_WORD, MODE_NUMBER, MODE_STRING, MODE_CHAR_Q,
    MODE_CHAR_V, MODE_EQ, MODE_BANG, MODE_HALT, MODE_DONE
  } mode_t;

  // fixed-width part of one result
  typedef struct packed {
    logic [6:0] kind;
    logic [7:0] chr;
    logic       is_chr;
    logic [1:0] err;
  } res_ctl_t;

  // keywords packed first byte lowest, so written reversed
  localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
    40'("ivs"), 40'("rol"), 40'("xor"), 40'("rod"), 40'("soc"), 40'("eub"),
    40'("sele"), 40'("eles"), 40'("trec"), 40'("hec"), 40'("ysu"), 40'("ncuf"),
    40'("ver"), 40'("poc"), 40'("pit"), 40'("vols"), 40'("rtp"), 40'("kta"),
    40'("paz"), 40'("orp"), 40'("kaz"), 40'("elif"), 40'("trqs"), 40'("sba"),
    40'("wop"), 40'("xam"), 40'("nim"), 40'("olf"), 40'("lec"), 40'("nor"),
    40'("nar"), 40'("dv"), 40'("wn"), 40'("led"), 40'("krb"), 40'("pmi"),
    40'("tnoc"), 40'("ra"), 40'("res"), 40'("per"), 40'("s_vv"), 40'("rts"),
    40'("rhc"), 40'("46xor"), 40'("eurt"), 40'("eslaf")
  };

  // returns {hit, index}
  function automatic logic [6:0] kw_match(logic [39:0] kw_buf, logic [2:0] len,
                                          logic len_ok);
    logic [6:0] res;
    logic [2:0] n;
    res = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      n = 3'd0;
      for (int b = 0; b < 5; b++) begin
        if (KW_TEXT[i][8*b +: 8] != 8'd0) n = n + 3'd1;
      end
      if (len_ok && n == len && KW_TEXT[i] == kw_buf) res = {1'b1, 6'(i)};
    end
    return res;
  endfunction

  // returns {hit, index}
  function automatic logic [4:0] punct_match(logic [7:0] c);
    logic [4:0] res;
    unique case (c)
      8'h3E:   res = {1'b1, 4'd0};
      8'h3C:   res = {1'b1, 4'd1};
      8'h2B:   res = {1'b1, 4'd2};
      8'h2D:   res = {1'b1, 4'd3};
      8'h2A:   res = {1'b1, 4'd4};
      8'h26:   res = {1'b1, 4'd5};
      8'h2F:   res = {1'b1, 4'd6};
      8'h3B:   res = {1'b1, 4'd7};
      8'h28:   res = {1'b1, 4'd8};
      8'h29:   res = {1'b1, 4'd9};
      8'h7B:   res = {1'b1, 4'd10};
      8'h7D:   res = {1'b1, 4'd11};
      8'h2C:   res = {1'b1, 4'd12};
      8'h5B:   res = {1'b1, 4'd13};
      8'h5D:   res = {1'b1, 4'd14};
      8'h2E:   res = {1'b1, 4'd15};
      default: res = 5'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/kls_step.sv */
// ----------------------------------------------------------------------------
// kls_step
// Next-state and result logic of the lexer for one byte or end of text.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_step #(
  parameter int LB = 16,
  parameter int CB = 16,
  parameter int NB = 16
) (
  input  var kls_pkg::mode_t mode_r,
  input  wire logic [LB-1:0] line_r,
  input  wire logic [CB-1:0] col_r,
  input  wire logic [LB-1:0] tline_r,
  input  wire logic [CB-1:0] tcol_r,
  input  wire logic [NB-1:0] tlen_r,
  input  wire logic [39:0]   kwbuf_r,
  input  wire logic [7:0]    lit_r,
  input  wire logic [7:0]    c,
  input  wire logic          eot,
  output kls_pkg::mode_t     mode_nxt,
  output logic [LB-1:0]      line_nxt,
  output logic [CB-1:0]      col_nxt,
  output logic [LB-1:0]      tline_nxt,
  output logic [CB-1:0]      tcol_nxt,
  output logic [NB-1:0]      tlen_nxt,
  output logic [39:0]        kwbuf_nxt,
  output logic [7:0]         lit_nxt,
  output logic [1:0]         n_res,
  output kls_pkg::res_ctl_t  ctl0,
  output logic [LB-1:0]      line0,
  output logic [CB-1:0]      col0,
  output logic [NB-1:0]      len0,
  output kls_pkg::res_ctl_t  ctl1,
  output logic [LB-1:0]      line1,
  output logic [CB-1:0]      col1,
  output logic [NB-1:0]      len1
);

  logic [LB-1:0] line_inc;
  logic [CB-1:0] col_inc;
  logic [NB-1:0] len_inc;
  logic          is_alpha, is_digit, is_space, word_ch;
  logic [6:0]    kw_hit;
  logic [4:0]    pu_hit;
  kls_pkg::res_ctl_t word_ctl;
  logic [NB-1:0] word_len;

  // start-of-token effects
  kls_pkg::mode_t    sb_mode;
  logic [LB-1:0]     sb_line;
  logic [CB-1:0]     sb_col;
  logic [NB-1:0]     sb_tlen;
  logic [39:0]       sb_kw;
  logic              sb_emit;
  kls_pkg::res_ctl_t sb_ctl;

  assign line_inc = (&line_r) ? line_r : line_r + 1'b1;
  assign col_inc  = (&col_r) ? col_r : col_r + 1'b1;
  assign len_inc  = (&tlen_r) ? tlen_r : tlen_r + 1'b1;

  assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_digit = c >= 8'h30 && c <= 8'h39;
  assign is_space = c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  assign word_ch  = is_alpha || is_digit || c == 8'h5F;

  // keyword compare on the open word
  assign kw_hit = kls_pkg::kw_match(kwbuf_r, tlen_r[2:0], tlen_r <= NB'(5));
  assign pu_hit = kls_pkg::punct_match(c);

  always_comb begin
    word_ctl = '0;
    word_ctl.kind = kw_hit[6] ? kls_pkg::KIND_KW0 + {1'b0, kw_hit[5:0]}
                              : kls_pkg::KIND_IDENT;
    word_len = kw_hit[6] ? '0 : tlen_r;
  end

  // byte with no token open
  always_comb begin
    sb_mode = kls_pkg::MODE_IDLE;
    sb_line = line_r;
    sb_col  = col_inc;
    sb_tlen = tlen_r;
    sb_kw   = kwbuf_r;
    sb_emit = 1'b0;
    sb_ctl  = '0;
    priority if (c == 8'h0A) begin
      sb_line = line_inc;
      sb_col  = CB'(1);
    end else if (is_space) begin
      sb_col = col_inc;
    end else if (is_alpha || c == 8'h5F) begin
      sb_mode = kls_pkg::MODE_WORD;
      sb_tlen = NB'(1);
      sb_kw   = {32'd0, c};
    end else if (is_digit) begin
      sb_mode = kls_pkg::MODE_NUMBER;
      sb_tlen = NB'(1);
    end else if (c == 8'h27) begin
      sb_mode = kls_pkg::MODE_CHAR_Q;
    end else if (c == 8'h22) begin
      sb_mode = kls_pkg::MODE_STRING;
      sb_tlen = '0;
    end else if (c == 8'h3D) begin
      sb_mode = kls_pkg::MODE_EQ;
    end else if (c == 8'h21) begin
      sb_mode = kls_pkg::MODE_BANG;
    end else if (pu_hit[4]) begin
      sb_emit = 1'b1;
      sb_ctl.kind = kls_pkg::KIND_PUNCT0 + {3'd0, pu_hit[3:0]};
    end else begin
      sb_mode = kls_pkg::MODE_HALT;
      sb_col  = col_r;
      sb_emit = 1'b1;
      sb_ctl.err = kls_pkg::ERR_UNKNOWN;
    end
  end

  // main transition
  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    tline_nxt = tline_r;
    tcol_nxt  = tcol_r;
    tlen_nxt  = tlen_r;
    kwbuf_nxt = kwbuf_r;
    lit_nxt   = lit_r;
    n_res     = 2'd0;
    ctl0 = '0;  line0 = tline_r;  col0 = tcol_r;  len0 = '0;
    ctl1 = '0;  line1 = line_r;   col1 = col_r;   len1 = '0;

    if (mode_r != kls_pkg::MODE_HALT && mode_r != kls_pkg::MODE_DONE) begin
      if (eot) begin
        // flush, then end marker unless halted
        mode_nxt = kls_pkg::MODE_DONE;
        n_res = 2'd2;
        unique case (mode_r)
          kls_pkg::MODE_WORD: begin
            ctl0 = word_ctl;
            len0 = word_len;
          end
          kls_pkg::MODE_NUMBER: begin
            ctl0.kind = kls_pkg::KIND_NUMBER;
            len0 = tlen_r;
          end
          kls_pkg::MODE_STRING: begin
            ctl0.kind = kls_pkg::KIND_STRING;
            len0 = tlen_r;
          end
          kls_pkg::MODE_EQ: ctl0.kind = kls_pkg::KIND_ASSIGN;
          kls_pkg::MODE_BANG: begin
            ctl0.err = kls_pkg::ERR_BANG;
            mode_nxt = kls_pkg::MODE_HALT;
            n_res = 2'd1;
          end
          kls_pkg::MODE_CHAR_Q, kls_pkg::MODE_CHAR_V: begin
            ctl0.err = kls_pkg::ERR_CHAR;
            mode_nxt = kls_pkg::MODE_HALT;
            n_res = 2'd1;
          end
          default: begin
            line0 = line_r;
            col0  = col_r;
            n_res = 2'd1;
          end
        endcase
      end else begin
        // byte transfer
        unique case (mode_r)
          kls_pkg::MODE_WORD, kls_pkg::MODE_NUMBER: begin
            if (word_ch && (mode_r == kls_pkg::MODE_WORD || is_digit || c == 8'h2E)) begin
              if (mode_r == kls_pkg::MODE_WORD && tlen_r < NB'(5))
                kwbuf_nxt = kwbuf_r | ({32'd0, c} << {tlen_r[2:0], 3'b000});
              tlen_nxt = len_inc;
              col_nxt  = col_inc;
            end else if (mode_r == kls_pkg::MODE_NUMBER && c == 8'h2E) begin
              tlen_nxt = len_inc;
              col_nxt  = col_inc;
            end else begin
              if (mode_r == kls_pkg::MODE_WORD) begin
                ctl0 = word_ctl;
                len0 = word_len;
              end else begin
                ctl0.kind = kls_pkg::KIND_NUMBER;
                len0 = tlen_r;
              end
              mode_nxt  = sb_mode;
              line_nxt  = sb_line;
              col_nxt   = sb_col;
              tline_nxt = line_r;
              tcol_nxt  = col_r;
              tlen_nxt  = sb_tlen;
              kwbuf_nxt = sb_kw;
              ctl1  = sb_ctl;
              n_res = sb_emit ? 2'd2 : 2'd1;
            end
          end
          kls_pkg::MODE_STRING: begin
            col_nxt = col_inc;
            if (c == 8'h22) begin
              ctl0.kind = kls_pkg::KIND_STRING;
              len0 = tlen_r;
              mode_nxt = kls_pkg::MODE_IDLE;
              n_res = 2'd1;
            end else begin
              tlen_nxt = len_inc;
            end
          end
          kls_pkg::MODE_CHAR_Q: begin
            lit_nxt  = c;
            col_nxt  = col_inc;
            mode_nxt = kls_pkg::MODE_CHAR_V;
          end
          kls_pkg::MODE_CHAR_V: begin
            col_nxt = col_inc;
            ctl0.kind   = kls_pkg::KIND_NUMBER;
            ctl0.chr    = lit_r;
            ctl0.is_chr = 1'b1;
            mode_nxt = kls_pkg::MODE_IDLE;
            n_res = 2'd1;
          end
          kls_pkg::MODE_EQ: begin
            if (c == 8'h3D) begin
              col_nxt = col_inc;
              ctl0.kind = kls_pkg::KIND_EQEQ;
              mode_nxt = kls_pkg::MODE_IDLE;
              n_res = 2'd1;
            end else begin
              ctl0.kind = kls_pkg::KIND_ASSIGN;
              mode_nxt  = sb_mode;
              line_nxt  = sb_line;
              col_nxt   = sb_col;
              tline_nxt = line_r;
              tcol_nxt  = col_r;
              tlen_nxt  = sb_tlen;
              kwbuf_nxt = sb_kw;
              ctl1  = sb_ctl;
              n_res = sb_emit ? 2'd2 : 2'd1;
            end
          end
          kls_pkg::MODE_BANG: begin
            n_res = 2'd1;
            if (c == 8'h3D) begin
              col_nxt = col_inc;
              ctl0.kind = kls_pkg::KIND_NOTEQ;
              mode_nxt = kls_pkg::MODE_IDLE;
            end else begin
              ctl0.err = kls_pkg::ERR_BANG;
              mode_nxt = kls_pkg::MODE_HALT;
            end
          end
          default: begin
            // idle: result of a start byte goes out first
            mode_nxt  = sb_mode;
            line_nxt  = sb_line;
            col_nxt   = sb_col;
            tline_nxt = line_r;
            tcol_nxt  = col_r;
            tlen_nxt  = sb_tlen;
            kwbuf_nxt = sb_kw;
            ctl0  = sb_ctl;
            line0 = line_r;
            col0  = col_r;
            n_res = sb_emit ? 2'd1 : 2'd0;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/kls_fifo.sv */
// ----------------------------------------------------------------------------
// kls_fifo
// Four-entry result queue taking up to two entries and giving one per cycle while popped.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_fifo #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       push_n,
  input  wire logic [WIDTH-1:0] din0,
  input  wire logic [WIDTH-1:0] din1,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic                  room2,
  output logic [WIDTH-1:0]      dout
);

  logic [WIDTH-1:0] mem_r [4];
  logic [1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] wr_p1;

  assign wr_p1     = wr_r + 2'd1;
  assign not_empty = cnt_r != 3'd0;
  assign room2     = cnt_r <= 3'd2;
  assign dout      = mem_r[rd_r];

  // pointer and fill update
  always_comb begin
    wr_nxt  = wr_r + push_n;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push_n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_r] <= din0;
    if (push_n == 2'd2) mem_r[wr_p1] <= din1;
  end

endmodule

`default_nettype wire

/* rtl/core/keyword_lexer_stream_top.sv */
// ----------------------------------------------------------------------------
// keyword_lexer_stream_top
// Streaming lexer: one source byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  in      | in_valid/in_stall, byte, eot   | source text into lexer
//  out     | out_valid/out_stall, token     | tokens out of lexer
//
//  one byte per cycle while not stalled: lexer state updates in the accepting cycle
//  results land in a four-entry queue; input stalls while it holds three or more
//  a byte causing two tokens pushes both at once; output drains one per cycle unless stalled
//  synchronous reset returns to line 1, column 1, idle
//  after END or an error all input is taken and dropped until reset
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_lexer_stream_top #(
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 16,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_char_byte,
  input  wire logic                   in_end_of_text,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [6:0]                  out_token_kind,
  output logic [LINE_BITS-1:0]        out_start_line,
  output logic [COLUMN_BITS-1:0]      out_start_column,
  output logic [LENGTH_BITS-1:0]      out_text_length,
  output logic [7:0]                  out_char_code,
  output logic                        out_is_char_literal,
  output logic [1:0]                  out_error_code,
  output logic                        out_last_of_run
);

  localparam int CTLW = $bits(kls_pkg::res_ctl_t);
  localparam int EW   = 1 + CTLW + LINE_BITS + COLUMN_BITS + LENGTH_BITS;

  kls_pkg::mode_t mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt, tline_r, tline_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt, tcol_r, tcol_nxt;
  logic [LENGTH_BITS-1:0] tlen_r, tlen_nxt;
  logic [39:0]            kwbuf_r, kwbuf_nxt;
  logic [7:0]             lit_r, lit_nxt;

  logic [1:0]             n_res;
  kls_pkg::res_ctl_t      ctl0, ctl1;
  logic [LINE_BITS-1:0]   line0, line1;
  logic [COLUMN_BITS-1:0] col0, col1;
  logic [LENGTH_BITS-1:0] len0, len1;

  logic          in_xfer, room2, not_empty;
  logic [EW-1:0] din0, din1, dout;
  kls_pkg::res_ctl_t ctl_out;

  assign in_stall = !room2;
  assign in_xfer  = in_valid && room2;

  kls_step #(.LB(LINE_BITS), .CB(COLUMN_BITS), .NB(LENGTH_BITS)) u_step (
    .mode_r(mode_r), .line_r(line_r), .col_r(col_r), .tline_r(tline_r),
    .tcol_r(tcol_r), .tlen_r(tlen_r), .kwbuf_r(kwbuf_r), .lit_r(lit_r),
    .c(in_char_byte), .eot(in_end_of_text),
    .mode_nxt(mode_nxt), .line_nxt(line_nxt), .col_nxt(col_nxt),
    .tline_nxt(tline_nxt), .tcol_nxt(tcol_nxt), .tlen_nxt(tlen_nxt),
    .kwbuf_nxt(kwbuf_nxt), .lit_nxt(lit_nxt), .n_res(n_res),
    .ctl0(ctl0), .line0(line0), .col0(col0), .len0(len0),
    .ctl1(ctl1), .line1(line1), .col1(col1), .len1(len1)
  );

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= kls_pkg::MODE_IDLE;
      line_r  <= LINE_BITS'(1);
      col_r   <= COLUMN_BITS'(1);
      tline_r <= LINE_BITS'(1);
      tcol_r  <= COLUMN_BITS'(1);
      tlen_r  <= '0;
      kwbuf_r <= '0;
      lit_r   <= '0;
    end else if (in_xfer) begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      tline_r <= tline_nxt;
      tcol_r  <= tcol_nxt;
      tlen_r  <= tlen_nxt;
      kwbuf_r <= kwbuf_nxt;
      lit_r   <= lit_nxt;
    end
  end

  // pack results, last flag on the final one
  assign din0 = {n_res == 2'd1, ctl0, line0, col0, len0};
  assign din1 = {1'b1, ctl1, line1, col1, len1};

  kls_fifo #(.WIDTH(EW)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push_n(in_xfer ? n_res : 2'd0), .din0(din0), .din1(din1),
    .pop(not_empty && !out_stall), .not_empty(not_empty), .room2(room2),
    .dout(dout)
  );

  // unpack head of queue
  assign out_valid        = not_empty;
  assign out_last_of_run  = dout[EW-1];
  assign ctl_out          = dout[EW-2 -: CTLW];
  assign out_start_line   = dout[COLUMN_BITS+LENGTH_BITS +: LINE_BITS];
  assign out_start_column = dout[LENGTH_BITS +: COLUMN_BITS];
  assign out_text_length  = dout[LENGTH_BITS-1:0];
  assign out_token_kind      = ctl_out.kind;
  assign out_char_code       = ctl_out.chr;
  assign out_is_char_literal = ctl_out.is_chr;
  assign out_error_code      = ctl_out.err;

endmodule

`default_nettype wire

/* tb/keyword_lexer_stream_top_tb.sv */
// ----------------------------------------------------------------------------
// keyword_lexer_stream_top_tb
// Streams generated source text into the lexer byte by byte, predicts every
// token in a behavioral lexer model and checks each token transfer in order.
// Both channels idle and stall at random; the text ends in END or an error.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keyword_lexer_stream_top_tb;

  typedef struct packed {
    logic       eot;
    logic [7:0] chr;
  } src_item_t;

  typedef struct packed {
    logic [6:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic [7:0]  chr;
    logic        is_chr;
    logic [1:0]  err;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_byte = 8'd0;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_token_kind;
  logic [15:0] out_start_line;
  logic [15:0] out_start_column;
  logic [15:0] out_text_length;
  logic [7:0]  out_char_code;
  logic        out_is_char_literal;
  logic [1:0]  out_error_code;
  logic        out_last_of_run;

  src_item_t pending_bytes[$];
  token_t    expected_tokens[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        src_count = 0;

  string keywords[kls_pkg::KW_COUNT] = '{
    "svi", "lor", "rox", "dor", "cos", "bue", "eles", "sele", "cert", "ceh",
    "usy", "fucn", "rev", "cop", "tip", "slov", "ptr", "atk", "zap", "pro",
    "zak", "file", "sqrt", "abs", "pow", "max", "min", "flo", "cel", "ron",
    "ran", "vd", "nw", "del", "brk", "imp", "cont", "ar", "ser", "rep",
    "vv_s", "str", "chr", "rox64", "true", "false"
  };
  string puncts = "><+-*&/;(){},[].";

  // lexer model state
  kls_pkg::mode_t lx_mode;
  logic [15:0] lx_line, lx_col, tok_line, tok_col, tok_len;
  logic [39:0] kw_buf;
  logic [7:0]  lit_byte;

  keyword_lexer_stream_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_char_byte(in_char_byte), .in_end_of_text(in_end_of_text),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_kind(out_token_kind), .out_start_line(out_start_line),
    .out_start_column(out_start_column), .out_text_length(out_text_length),
    .out_char_code(out_char_code), .out_is_char_literal(out_is_char_literal),
    .out_error_code(out_error_code), .out_last_of_run(out_last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic push_token(logic [6:0] kind, logic [15:0] ln, logic [15:0] cl,
                            logic [15:0] len, logic [7:0] ch, logic isc,
                            logic [1:0] er);
    expected_tokens.insert(expected_tokens.size(),
                           token_t'{kind, ln, cl, len, ch, isc, er, 1'b0});
  endtask

  task automatic add_src(logic eot, logic [7:0] c);
    pending_bytes.insert(pending_bytes.size(), src_item_t'{eot, c});
  endtask

  task automatic flush_word();
    logic [39:0] packed_kw;
    logic [6:0]  kind;
    kind = kls_pkg::KIND_IDENT;
    if (tok_len <= 16'd5) begin
      for (int i = 0; i < kls_pkg::KW_COUNT; i++) begin
        packed_kw = '0;
        for (int n = 0; n < keywords[i].len(); n++)
          packed_kw[8*n +: 8] = keywords[i][n];
        if (keywords[i].len() == tok_len && packed_kw == kw_buf &&
            kind == kls_pkg::KIND_IDENT)
          kind = kls_pkg::KIND_KW0 + 7'(i);
      end
    end
    push_token(kind, tok_line, tok_col, (kind == kls_pkg::KIND_IDENT) ? tok_len : 16'd0,
               8'd0, 1'b0, kls_pkg::ERR_NONE);
  endtask

  task automatic halt_with(logic [15:0] ln, logic [15:0] cl, logic [1:0] er);
    lx_mode = kls_pkg::MODE_HALT;
    push_token(kls_pkg::KIND_END, ln, cl, 16'd0, 8'd0, 1'b0, er);
  endtask

  // byte arriving with no token open
  task automatic open_token(logic [7:0] c);
    int p;
    if (c == 8'h0A) begin
      lx_line = sat_inc(lx_line);
      lx_col = 16'd1;
      return;
    end
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      lx_col = sat_inc(lx_col);
      return;
    end
    tok_line = lx_line;
    tok_col = lx_col;
    p = -1;
    for (int i = 0; i < 16; i++) if (puncts[i] == c) p = i;
    if (is_alpha(c) || c == "_") begin
      lx_mode = kls_pkg::MODE_WORD;
      tok_len = 16'd1;
      kw_buf = {32'd0, c};
    end else if (is_digit(c)) begin
      lx_mode = kls_pkg::MODE_NUMBER;
      tok_len = 16'd1;
    end else if (c == "'") begin
      lx_mode = kls_pkg::MODE_CHAR_Q;
    end else if (c == "\"") begin
      lx_mode = kls_pkg::MODE_STRING;
      tok_len = 16'd0;
    end else if (c == "=") begin
      lx_mode = kls_pkg::MODE_EQ;
    end else if (c == "!") begin
      lx_mode = kls_pkg::MODE_BANG;
    end else if (p >= 0) begin
      lx_col = sat_inc(lx_col);
      push_token(kls_pkg::KIND_PUNCT0 + 7'(p), tok_line, tok_col, 16'd0, 8'd0, 1'b0,
                 kls_pkg::ERR_NONE);
      return;
    end else begin
      halt_with(tok_line, tok_col, kls_pkg::ERR_UNKNOWN);
      return;
    end
    lx_col = sat_inc(lx_col);
  endtask

  // expected tokens for one accepted source transfer
  task automatic lex_byte(logic [7:0] c, logic eot);
    int n0;
    n0 = expected_tokens.size();
    if (lx_mode == kls_pkg::MODE_HALT || lx_mode == kls_pkg::MODE_DONE) return;
    if (eot) begin
      case (lx_mode)
        kls_pkg::MODE_WORD: flush_word();
        kls_pkg::MODE_NUMBER:
          push_token(kls_pkg::KIND_NUMBER, tok_line, tok_col, tok_len, 8'd0, 1'b0,
                     kls_pkg::ERR_NONE);
        kls_pkg::MODE_STRING:
          push_token(kls_pkg::KIND_STRING, tok_line, tok_col, tok_len, 8'd0, 1'b0,
                     kls_pkg::ERR_NONE);
        kls_pkg::MODE_EQ:
          push_token(kls_pkg::KIND_ASSIGN, tok_line, tok_col, 16'd0, 8'd0, 1'b0,
                     kls_pkg::ERR_NONE);
        kls_pkg::MODE_BANG: halt_with(tok_line, tok_col, kls_pkg::ERR_BANG);
        kls_pkg::MODE_CHAR_Q, kls_pkg::MODE_CHAR_V:
          halt_with(tok_line, tok_col, kls_pkg::ERR_CHAR);
        default: ;
      endcase
      if (lx_mode != kls_pkg::MODE_HALT) begin
        push_token(kls_pkg::KIND_END, lx_line, lx_col, 16'd0, 8'd0, 1'b0, kls_pkg::ERR_NONE);
        lx_mode = kls_pkg::MODE_DONE;
      end
    end else begin
      case (lx_mode)
        kls_pkg::MODE_WORD:
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            if (tok_len < 16'd5) kw_buf[8*tok_len[2:0] +: 8] = c;
            tok_len = sat_inc(tok_len);
            lx_col = sat_inc(lx_col);
          end else begin
            flush_word();
            lx_mode = kls_pkg::MODE_IDLE;
            open_token(c);
          end
        kls_pkg::MODE_NUMBER:
          if (is_digit(c) || c == ".") begin
            tok_len = sat_inc(tok_len);
            lx_col = sat_inc(lx_col);
          end else begin
            push_token(kls_pkg::KIND_NUMBER, tok_line, tok_col, tok_len, 8'd0, 1'b0,
                       kls_pkg::ERR_NONE);
            lx_mode = kls_pkg::MODE_IDLE;
            open_token(c);
          end
        kls_pkg::MODE_STRING: begin
          lx_col = sat_inc(lx_col);
          if (c == "\"") begin
            push_token(kls_pkg::KIND_STRING, tok_line, tok_col, tok_len, 8'd0, 1'b0,
                       kls_pkg::ERR_NONE);
            lx_mode = kls_pkg::MODE_IDLE;
          end else begin
            tok_len = sat_inc(tok_len);
          end
        end
        kls_pkg::MODE_CHAR_Q: begin
          lit_byte = c;
          lx_col = sat_inc(lx_col);
          lx_mode = kls_pkg::MODE_CHAR_V;
        end
        kls_pkg::MODE_CHAR_V: begin
          lx_col = sat_inc(lx_col);
          push_token(kls_pkg::KIND_NUMBER, tok_line, tok_col, 16'd0, lit_byte, 1'b1,
                     kls_pkg::ERR_NONE);
          lx_mode = kls_pkg::MODE_IDLE;
        end
        kls_pkg::MODE_EQ: begin
          lx_mode = kls_pkg::MODE_IDLE;
          if (c == "=") begin
            lx_col = sat_inc(lx_col);
            push_token(kls_pkg::KIND_EQEQ, tok_line, tok_col, 16'd0, 8'd0, 1'b0,
                       kls_pkg::ERR_NONE);
          end else begin
            push_token(kls_pkg::KIND_ASSIGN, tok_line, tok_col, 16'd0, 8'd0, 1'b0,
                       kls_pkg::ERR_NONE);
            open_token(c);
          end
        end
        kls_pkg::MODE_BANG:
          if (c == "=") begin
            lx_col = sat_inc(lx_col);
            lx_mode = kls_pkg::MODE_IDLE;
            push_token(kls_pkg::KIND_NOTEQ, tok_line, tok_col, 16'd0, 8'd0, 1'b0,
                       kls_pkg::ERR_NONE);
          end else begin
            halt_with(tok_line, tok_col, kls_pkg::ERR_BANG);
          end
        default: open_token(c);
      endcase
    end
    if (expected_tokens.size() > n0) expected_tokens[$].last = 1'b1;
  endtask

  // source text building
  task automatic put_byte(logic [7:0] c);
    add_src(1'b0, c);
    src_count++;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_separator();
    case ($urandom_range(0, 7))
      0, 1, 2: put_byte(" ");
      3: put_byte(8'($urandom_range(9, 13)));
      4: put_byte(8'h0A);
      default: put_byte(puncts[$urandom_range(0, 15)]);
    endcase
  endtask

  task automatic put_random_token();
    string word_chars;
    int    n;
    logic [7:0] b;
    word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    case ($urandom_range(0, 11))
      0, 1, 2: put_text(keywords[$urandom_range(0, kls_pkg::KW_COUNT - 1)]);
      3, 4: begin
        // identifier, occasionally a keyword prefix or extension
        if ($urandom_range(0, 3) == 0)
          put_text(keywords[$urandom_range(0, kls_pkg::KW_COUNT - 1)]);
        else put_byte(word_chars[$urandom_range(0, 52)]);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) put_byte(word_chars[$urandom_range(0, 62)]);
      end
      5: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          put_byte(($urandom_range(0, 4) == 0 && i > 0) ? "." : 8'($urandom_range(48, 57)));
      end
      6: begin
        put_byte("\"");
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          put_byte(b == "\"" ? 8'h0A : b);
        end
        put_byte("\"");
      end
      7: begin
        put_byte("'");
        put_byte(8'($urandom_range(0, 255)));
        put_byte(8'($urandom_range(0, 255)));
      end
      8: put_text($urandom_range(0, 1) ? "==" : "!=");
      9: put_byte("=");
      default: put_byte(puncts[$urandom_range(0, 15)]);
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    logic load;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      cycle_count++;
      if (in_valid && !in_stall) lex_byte(in_char_byte, in_end_of_text);
      if (!in_valid || !in_stall) begin
        load = pending_bytes.size() > 0 &&
               ((cycle_count > 1500 && cycle_count < 2500) || $urandom_range(0, 99) >= 14);
        in_valid <= load;
        if (load) begin
          in_char_byte <= pending_bytes[0].chr;
          in_end_of_text <= pending_bytes[0].eot;
          void'(pending_bytes.pop_front());
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    token_t got;
    if (rst_n) begin
      got = '{out_token_kind, out_start_line, out_start_column, out_text_length,
              out_char_code, out_is_char_literal, out_error_code, out_last_of_run};
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token transfer: %p", got);
        end else begin
          if (got != expected_tokens[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("token mismatch: expected %p actual %p", expected_tokens[0], got);
          end
          void'(expected_tokens.pop_front());
        end
      end
      out_stall <= !(cycle_count > 1500 && cycle_count < 2500) && $urandom_range(0, 99) < 14;
    end
  end

  // stimulus and end of run
  initial begin
    int ending;
    lx_mode = kls_pkg::MODE_IDLE;
    lx_line = 16'd1; lx_col = 16'd1; tok_line = 16'd1; tok_col = 16'd1;
    tok_len = 16'd0; kw_buf = '0; lit_byte = 8'd0;

    // directed: longest keyword, merged word, both lookaheads, extreme literals
    put_text("rox64 a_9=='");
    put_byte(8'h00);
    put_text("' '");
    put_byte(8'hFF);
    put_text("'!=\"");
    put_byte(8'hFF);
    put_text("\n\"5.\n");

    while (src_count < 1950) begin
      put_random_token();
      put_separator();
    end

    // the text ends once: normally, or in one of the halting errors
    ending = $urandom_range(0, 5);
    if ($urandom_range(0, 1)) put_random_token();
    case (ending)
      1: put_byte($urandom_range(0, 1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 8)));
      2: begin
        put_byte("!");
        if ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 1) ? 32 : 65));
      end
      3: begin
        put_byte("'");
        if ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 255)));
      end
      4: put_text("\"open");
      default: ;
    endcase
    add_src(1'b1, 8'd0);
    // dropped after END or halt
    for (int i = 0; i < 12; i++)
      add_src(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_bytes.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
